[rtl/ipv4_lpm_pkg.sv]
// Shared types and constants for the IPv4 longest prefix match engine.
// Used by the route table memory, the top level and the port checker.
package ipv4_lpm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 11;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;

    // request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    // write side of the route table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        route_entry_t     entry;
    } table_wr_t;

    // read side of the route table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } table_rd_t;

    // lookup sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } lpm_state_t;

endpackage

[rtl/ipv4_lpm_table.sv]
// Route table storage: one write port, one registered read port.
// Depends on ipv4_lpm_pkg for the entry and port structs.
module ipv4_lpm_table (
    input  logic                      clk,
    input  ipv4_lpm_pkg::table_wr_t   wr,
    input  ipv4_lpm_pkg::table_rd_t   rd,
    output ipv4_lpm_pkg::route_entry_t rd_data
);
    import ipv4_lpm_pkg::*;

    route_entry_t route_mem [TABLE_DEPTH];
    route_entry_t rd_data_reg;

    // route write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            route_mem[wr.addr] <= wr.entry;
        end
    end

    // registered read for the scan
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= route_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ipv4_longest_prefix_match.sv]
// IPv4 longest prefix match engine: top level with sequencer and compare unit.
// Depends on ipv4_lpm_pkg and ipv4_lpm_table.
// Write request: taken with no result, the next request can follow at once.
// Lookup: one entry read per cycle over N = min(table_length, 1024) entries, then a drain step
// (neither when N is 0); the result loads into the output register once it is free; then idle.
// Reset clears the sequencer, table_length and the output valid; table contents keep.
module ipv4_longest_prefix_match (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [ipv4_lpm_pkg::LEN_W-1:0]    cfg_wdata,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [9:0]                        entry_index,
    input  logic [31:0]                       entry_prefix,
    input  logic [31:0]                       entry_mask,
    input  logic [31:0]                       entry_next_hop,
    input  logic [7:0]                        entry_port,
    input  logic [31:0]                       dest_addr,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              route_found,
    output logic [31:0]                       hop_addr,
    output logic [7:0]                        out_port
);
    import ipv4_lpm_pkg::*;

    lpm_state_t state_reg, state_next;

    logic [LEN_W-1:0]  table_length_reg;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] best_mask_reg, best_mask_next;
    logic [ADDR_W-1:0] best_hop_reg, best_hop_next;
    logic [PORT_W-1:0] best_port_reg, best_port_next;

    logic              out_valid_reg, out_valid_next;
    logic              route_found_reg;
    logic [ADDR_W-1:0] hop_addr_reg;
    logic [PORT_W-1:0] out_port_reg;

    logic              req_accept;
    logic              lookup_start;
    logic              rd_issue;
    logic              res_load;
    logic [LEN_W-1:0]  scan_count;
    logic              entry_match;
    logic              entry_better;

    table_wr_t    tbl_wr;
    table_rd_t    tbl_rd;
    route_entry_t tbl_data;

    // table length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            table_length_reg <= cfg_wdata;
        end
    end

    // entries to scan, capped at the table depth
    assign scan_count = (table_length_reg > LEN_W'(TABLE_DEPTH)) ?
                        LEN_W'(TABLE_DEPTH) : table_length_reg;

    assign req_accept   = in_valid && !in_stall;
    assign lookup_start = req_accept && (req_type == REQ_LOOKUP);

    // route table
    assign tbl_wr.en          = req_accept && (req_type == REQ_WRITE);
    assign tbl_wr.addr        = entry_index[IDX_W-1:0];
    assign tbl_wr.entry.prefix = entry_prefix;
    assign tbl_wr.entry.mask   = entry_mask;
    assign tbl_wr.entry.hop    = entry_next_hop;
    assign tbl_wr.entry.port   = entry_port;
    assign tbl_rd.en          = rd_issue;
    assign tbl_rd.addr        = addr_reg;

    ipv4_lpm_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_data)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_start)
                begin
                    state_next = (scan_count == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        rd_issue = 1'b0;
        res_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                rd_issue = 1'b0;
            end
            ST_FINISH:
            begin
                res_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
        end
    end

    // scan address, counts down from the last entry in use
    always_comb
    begin
        addr_next = addr_reg;
        if (lookup_start)
        begin
            addr_next = IDX_W'(scan_count - LEN_W'(1));
        end
        else if (rd_issue)
        begin
            addr_next = addr_reg - IDX_W'(1);
        end
    end

    // shared compare unit: prefix match and strictly greater mask value
    assign entry_match  = ((dest_reg & tbl_data.mask) == tbl_data.prefix);
    assign entry_better = !found_reg || (tbl_data.mask > best_mask_reg);

    // best route so far
    always_comb
    begin
        found_next     = found_reg;
        best_mask_next = best_mask_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        if (lookup_start)
        begin
            found_next = 1'b0;
        end
        else if (rd_valid_reg && entry_match && entry_better)
        begin
            found_next     = 1'b1;
            best_mask_next = tbl_data.mask;
            best_hop_next  = tbl_data.hop;
            best_port_next = tbl_data.port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        best_mask_reg <= best_mask_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        if (lookup_start)
        begin
            dest_reg <= dest_addr;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            route_found_reg <= found_reg;
            hop_addr_reg    <= found_reg ? best_hop_reg : '0;
            out_port_reg    <= found_reg ? best_port_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign route_found = route_found_reg;
    assign hop_addr    = hop_addr_reg;
    assign out_port    = out_port_reg;

endmodule

[rtl/ipv4_lpm_checker.sv]
// Port level checks for the IPv4 longest prefix match engine.
// Depends on the top level port list; attached by the bind at the end.
module ipv4_lpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic        route_found,
    input logic [31:0] hop_addr,
    input logic [7:0]  out_port
);
    import ipv4_lpm_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a miss carries zero next hop and port
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !route_found |-> (hop_addr == '0) && (out_port == '0))
        else $error("miss result with nonzero payload");

    // a route write never raises a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_WRITE) |=> !$rose(out_valid))
        else $error("result after route write");

    // the engine is busy right after a lookup request
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_LOOKUP) |=> in_stall)
        else $error("request taken during lookup");

endmodule

bind ipv4_longest_prefix_match ipv4_lpm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .route_found (route_found),
    .hop_addr    (hop_addr),
    .out_port    (out_port)
);

[tb/sv/ipv4_longest_prefix_match_test.sv]
// Self-checking bench for the IPv4 longest prefix match engine: directed routes,
// a partial table fill and random lookups, checked against an in-bench route predictor.
// Depends on ipv4_lpm_pkg and ipv4_longest_prefix_match.
module ipv4_longest_prefix_match_test;

    import ipv4_lpm_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int FILL_DEPTH = 128;

    // one request as driven on the input channel
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        route_entry_t      entry;
        logic [ADDR_W-1:0] dest;
    } route_req_t;

    // one lookup answer
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_WRITE;
    logic [9:0]  entry_index = '0;
    logic [31:0] entry_prefix = '0;
    logic [31:0] entry_mask = '0;
    logic [31:0] entry_next_hop = '0;
    logic [7:0]  entry_port = '0;
    logic [31:0] dest_addr = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        route_found;
    logic [31:0] hop_addr;
    logic [7:0]  out_port;

    // predictor state: shadow route table and table length
    route_entry_t     route_tbl [TABLE_DEPTH];
    logic [LEN_W-1:0] table_len = '0;

    route_req_t    pending_reqs [$];
    route_result_t expected_routes [$];
    route_req_t    cur_req;

    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned tx_max_gap = 14;
    int unsigned rx_max_gap = 14;
    int unsigned idle_cycles = 0;
    int unsigned fail_count = 0;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    ipv4_longest_prefix_match dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .entry_prefix   (entry_prefix),
        .entry_mask     (entry_mask),
        .entry_next_hop (entry_next_hop),
        .entry_port     (entry_port),
        .dest_addr      (dest_addr),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .route_found    (route_found),
        .hop_addr       (hop_addr),
        .out_port       (out_port)
    );

    always #4 clk = ~clk;

    // best route for a destination over the entries in use
    function automatic route_result_t best_route(logic [ADDR_W-1:0] dest);
        route_result_t res;
        int unsigned   count;
        int            best;
        int            i;
        res = '0;
        best = -1;
        count = 32'(table_len);
        if (count > TABLE_DEPTH)
            count = TABLE_DEPTH;
        for (i = int'(count) - 1; i >= 0; i--)
        begin
            if ((dest & route_tbl[i].mask) == route_tbl[i].prefix)
            begin
                if (best < 0 || route_tbl[i].mask > route_tbl[best].mask)
                    best = i;
            end
        end
        if (best >= 0)
        begin
            res.found = 1'b1;
            res.hop   = route_tbl[best].hop;
            res.port  = route_tbl[best].port;
        end
        return res;
    endfunction

    // entries actually scanned for a given length
    function automatic int unsigned used_entries(int unsigned len);
        return (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    endfunction

    function automatic route_req_t write_req(int unsigned idx, logic [31:0] prefix,
                                             logic [31:0] mask, logic [31:0] hop,
                                             logic [7:0] port);
        route_req_t req;
        req.kind         = REQ_WRITE;
        req.idx          = idx[IDX_W-1:0];
        req.entry.prefix = prefix;
        req.entry.mask   = mask;
        req.entry.hop    = hop;
        req.entry.port   = port;
        req.dest         = $urandom;
        return req;
    endfunction

    // lookup request, entry fields carry junk that must be ignored
    function automatic route_req_t lookup_req(logic [31:0] dest);
        route_req_t req;
        req.kind         = REQ_LOOKUP;
        req.idx          = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        req.entry.prefix = $urandom;
        req.entry.mask   = $urandom;
        req.entry.hop    = $urandom;
        req.entry.port   = 8'($urandom_range(0, 255));
        req.dest         = dest;
        return req;
    endfunction

    // random route, mostly a contiguous mask with a masked prefix
    function automatic route_req_t random_route(int unsigned idx);
        int          plen;
        logic [31:0] mask;
        logic [31:0] prefix;
        plen = $urandom_range(0, ADDR_W);
        mask = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
        if ($urandom_range(0, 15) == 0)
            mask = $urandom;
        prefix = $urandom & mask;
        if ($urandom_range(0, 31) == 0)
            prefix = $urandom;
        return write_req(idx, prefix, mask, $urandom, 8'($urandom_range(0, 255)));
    endfunction

    // write mostly inside the scanned range, sometimes cloning a route to force a tie
    function automatic route_req_t table_write(int unsigned len);
        route_req_t  req;
        int unsigned span;
        int unsigned idx;
        int unsigned j;
        span = (len == 0) ? 1 : used_entries(len);
        if ($urandom_range(0, 9) < 7)
            idx = $urandom_range(0, span - 1);
        else
            idx = $urandom_range(0, TABLE_DEPTH - 1);
        req = random_route(idx);
        if ($urandom_range(0, 3) == 0)
        begin
            j = $urandom_range(0, span - 1);
            req.entry.prefix = route_tbl[j].prefix;
            req.entry.mask   = route_tbl[j].mask;
        end
        return req;
    endfunction

    // destination aimed at a live route, or random, all zeros or all ones
    function automatic logic [31:0] pick_dest(int unsigned len);
        int unsigned sel;
        int unsigned i;
        sel = $urandom_range(0, 9);
        if (sel < 6 && len > 0)
        begin
            i = $urandom_range(0, used_entries(len) - 1);
            return (route_tbl[i].prefix & route_tbl[i].mask) | ($urandom & ~route_tbl[i].mask);
        end
        else if (sel < 8)
            return $urandom;
        else if (sel == 8)
            return '0;
        else
            return '1;
    endfunction

    // wait until every request is taken and every answer is back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_routes.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_table_length(int unsigned len);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len[LEN_W-1:0];
        table_len = len[LEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            // predict on acceptance
            if (in_fire)
            begin
                if (cur_req.kind == REQ_WRITE)
                    route_tbl[cur_req.idx] = cur_req.entry;
                else
                    expected_routes.push_back(best_route(cur_req.dest));
            end
            // launch next request unless the current one is held
            if (!(in_valid && in_stall))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req_type       <= cur_req.kind;
                    entry_index    <= cur_req.idx;
                    entry_prefix   <= cur_req.entry.prefix;
                    entry_mask     <= cur_req.entry.mask;
                    entry_next_hop <= cur_req.entry.hop;
                    entry_port     <= cur_req.entry.port;
                    dest_addr      <= cur_req.dest;
                    in_valid       <= 1'b1;
                    tx_gap = $urandom_range(0, tx_max_gap);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        route_result_t exp_res;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_fire)
            begin
                if (expected_routes.size() == 0)
                begin
                    $error("result with no lookup pending: found %0d hop %h port %0d",
                           route_found, hop_addr, out_port);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_routes.pop_front();
                    if (route_found !== exp_res.found)
                    begin
                        $error("route_found: expected %0d, got %0d", exp_res.found, route_found);
                        fail_count++;
                    end
                    if (hop_addr !== exp_res.hop)
                    begin
                        $error("hop_addr: expected %h, got %h", exp_res.hop, hop_addr);
                        fail_count++;
                    end
                    if (out_port !== exp_res.port)
                    begin
                        $error("out_port: expected %0d, got %0d", exp_res.port, out_port);
                        fail_count++;
                    end
                end
                rx_wait = $urandom_range(0, rx_max_gap);
            end
            else if (out_valid && rx_wait > 0)
                rx_wait--;
            out_stall <= (rx_wait > 0);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire || out_fire)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int unsigned random_items;
        int unsigned len;
        int unsigned n;
        int unsigned k;
        int unsigned sel;
        random_items = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table straight out of reset
        pending_reqs.push_back(lookup_req(32'h0000_0000));
        wait_quiet();

        // directed routes: /8, tied /16 pair, /24, host routes, default, /20
        pending_reqs.push_back(write_req(0, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_00fe, 8'd1));
        pending_reqs.push_back(write_req(1, 32'hc0a8_0000, 32'hffff_0000, 32'hc0a8_0001, 8'd2));
        pending_reqs.push_back(write_req(2, 32'hc0a8_0100, 32'hffff_ff00, 32'hc0a8_01fe, 8'd3));
        pending_reqs.push_back(write_req(3, 32'hc0a8_0000, 32'hffff_0000, 32'hc0a8_00fe, 8'd4));
        pending_reqs.push_back(write_req(4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'hff));
        pending_reqs.push_back(write_req(5, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00));
        pending_reqs.push_back(write_req(6, 32'h0000_0000, 32'hffff_ffff, 32'h0102_0304, 8'h80));
        pending_reqs.push_back(write_req(7, 32'h0a00_0000, 32'hffff_f000, 32'h0a00_0ffe, 8'd7));
        wait_quiet();

        // no default route in range: hits, tie, all-ones host, misses
        set_table_length(5);
        pending_reqs.push_back(lookup_req(32'h0a01_0203));
        pending_reqs.push_back(lookup_req(32'hc0a8_0105));
        pending_reqs.push_back(lookup_req(32'hc0a8_0205));
        pending_reqs.push_back(lookup_req(32'hffff_ffff));
        pending_reqs.push_back(lookup_req(32'h0808_0808));
        pending_reqs.push_back(lookup_req(32'h0000_0000));
        wait_quiet();

        // default route with zero hop, host route over default, longer prefix wins
        set_table_length(8);
        pending_reqs.push_back(lookup_req(32'h0808_0808));
        pending_reqs.push_back(lookup_req(32'h0000_0000));
        pending_reqs.push_back(lookup_req(32'h0a00_0005));
        pending_reqs.push_back(lookup_req(32'hc0a8_0105));
        wait_quiet();

        // single entry table
        set_table_length(1);
        pending_reqs.push_back(lookup_req(32'h0a00_0001));
        pending_reqs.push_back(lookup_req(32'h0b00_0000));
        wait_quiet();

        // fill the low part of the table so every length in use can be scanned
        for (k = 8; k < FILL_DEPTH; k++)
            pending_reqs.push_back(random_route(k));
        wait_quiet();

        // every filled entry in use
        set_table_length(FILL_DEPTH);
        pending_reqs.push_back(lookup_req(pick_dest(FILL_DEPTH)));
        pending_reqs.push_back(lookup_req((route_tbl[FILL_DEPTH-1].prefix &
                                           route_tbl[FILL_DEPTH-1].mask) |
                                          ($urandom & ~route_tbl[FILL_DEPTH-1].mask)));
        pending_reqs.push_back(lookup_req($urandom));
        pending_reqs.push_back(lookup_req(32'hffff_ffff));
        wait_quiet();

        // random phases over many table lengths and idle patterns
        while (random_items < 430)
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
                len = 0;
            else if (sel == 1)
                len = 1;
            else if (sel == 2)
                len = $urandom_range(65, FILL_DEPTH);
            else
                len = $urandom_range(2, 48);
            tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 14;
            rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 14;
            set_table_length(len);
            n = (len > 64) ? 4 : $urandom_range(12, 36);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) < 3)
                    pending_reqs.push_back(table_write(len));
                else
                    pending_reqs.push_back(lookup_req(pick_dest(len)));
            end
            random_items += n;
            wait_quiet();
        end

        repeat (8) @(posedge clk);
        if (expected_routes.size() != 0)
        begin
            $error("%0d lookup results never arrived", expected_routes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[ipv4_longest_prefix_match.f]
rtl/ipv4_lpm_pkg.sv
rtl/ipv4_lpm_table.sv
rtl/ipv4_longest_prefix_match.sv
rtl/ipv4_lpm_checker.sv
tb/sv/ipv4_longest_prefix_match_test.sv
